/* sv/krt_pkg.sv */
// Shared constants, codes and types for the keyed record table.
package krt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned NAME_BYTES = 20;
  localparam int unsigned NAME_W     = 8 * NAME_BYTES;
  localparam int unsigned POS_W      = 7;

  // Stream widths
  localparam int unsigned IN_W  = 208;
  localparam int unsigned OUT_W = 56;

  typedef enum logic [1:0] {
    FN_APPEND    = 2'd0,
    FN_DELETE    = 2'd1,
    FN_FIND_KEY  = 2'd2,
    FN_FIND_NAME = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One stored record, key in the low bits
  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [TAG_W-1:0]  tag;
    logic [KEY_W-1:0]  key;
  } rec_t;

  // Input transaction, func in the low bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] name_bytes_hi;
    logic [63:0] name_bytes_mid;
    logic [63:0] name_bytes_lo;
    logic [7:0]  rec_tag;
    logic [31:0] rec_key;
    func_e       func;
  } in_item_t;

  // Output transaction, status in the low bits
  typedef struct packed {
    logic [7:0]       found_tag;
    logic [31:0]      found_key;
    logic [POS_W-1:0] entry_count;
    logic [POS_W-1:0] position;
    status_e          status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic append;
    logic scan;
    logic shift;
    logic shrink;
    logic respond;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_append;
    logic op_delete;
    logic match;
    logic scan_end;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* sv/krt_ctrl.sv */
// Sequencing state machine for the keyed record table.
module krt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  krt_pkg::ctrl_sts_t sts_i,
  output krt_pkg::ctrl_cmd_t cmd_o
);
  import krt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Take a transaction only between operations
  assign s_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_append ? S_APPEND : S_SCAN;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        priority if (sts_i.match) begin
          state_d = sts_i.op_delete ? S_SHIFT : S_RESP;
        end else if (sts_i.scan_end) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (sts_i.scan_end) begin
          cmd_o.shrink = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/krt_dpath.sv */
// Record memory, scan and shift pointers, match logic and result register.
module krt_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  krt_pkg::ctrl_cmd_t cmd_i,
  output krt_pkg::ctrl_sts_t sts_o,
  input  krt_pkg::in_item_t  item_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output krt_pkg::out_item_t out_item_o
);
  import krt_pkg::*;

  // Name compare with string semantics: bytes after the first zero are ignored
  function automatic logic name_equal(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
    logic ok;
    logic ended;
    ok    = 1'b1;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!ended && (a[8*i +: 8] != b[8*i +: 8])) ok = 1'b0;
      ended = ended | (a[8*i +: 8] == 8'h00);
    end
    return ok;
  endfunction

  // Record memory
  rec_t mem_q [CAPACITY];
  rec_t rdata_q;
  logic we, re;
  logic [IDX_W-1:0] waddr, raddr;
  rec_t wdata;

  // Control state
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic rvld_q, rvld_d;
  logic hit_q, hit_d;
  logic full_q, full_d;
  logic out_vld_q, out_vld_d;

  // Operation and hit payload
  func_e            op_q;
  logic [KEY_W-1:0] key_q;
  logic [TAG_W-1:0] tag_q;
  logic [NAME_W-1:0] name_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [KEY_W-1:0] hit_key_q;
  logic [TAG_W-1:0] hit_tag_q;
  out_item_t        out_q;
  out_item_t        res;

  logic more;
  logic match_now;
  logic show;

  assign more      = (ptr_q < fill_q);
  assign match_now = rvld_q && ((op_q == FN_FIND_NAME) ? name_equal(rdata_q.name, name_q)
                                                       : (rdata_q.key == key_q));

  assign sts_o.in_append = (item_i.func == FN_APPEND);
  assign sts_o.op_delete = (op_q == FN_DELETE);
  assign sts_o.match     = match_now;
  assign sts_o.scan_end  = !rvld_q && !more;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // Pointer, fill and memory port control
  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    ridx_d = ridx_q;
    rvld_d = rvld_q;
    hit_d  = hit_q;
    full_d = full_q;
    we     = 1'b0;
    re     = 1'b0;
    waddr  = fill_q[IDX_W-1:0];
    raddr  = ptr_q[IDX_W-1:0];
    wdata  = rdata_q;

    if (cmd_i.load) begin
      ptr_d  = '0;
      rvld_d = 1'b0;
      hit_d  = 1'b0;
      full_d = 1'b0;
    end

    // Write at the end of the table, or flag full
    if (cmd_i.append) begin
      if (fill_q == CNT_W'(CAPACITY)) begin
        full_d = 1'b1;
      end else begin
        we         = 1'b1;
        wdata.key  = key_q;
        wdata.tag  = tag_q;
        wdata.name = name_q;
        fill_d     = fill_q + CNT_W'(1);
      end
    end

    // On a hit restart reads just past it for a possible shift
    if (cmd_i.scan && match_now) begin
      hit_d  = 1'b1;
      ptr_d  = CNT_W'(ridx_q) + CNT_W'(1);
      rvld_d = 1'b0;
    end else if (cmd_i.scan || cmd_i.shift) begin
      if (more) begin
        re     = 1'b1;
        ptr_d  = ptr_q + CNT_W'(1);
        ridx_d = ptr_q[IDX_W-1:0];
        rvld_d = 1'b1;
      end else begin
        rvld_d = 1'b0;
      end
    end

    // Move each later record one place forward
    if (cmd_i.shift && rvld_q) begin
      we    = 1'b1;
      waddr = ridx_q - IDX_W'(1);
      wdata = rdata_q;
    end

    if (cmd_i.shrink) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  // Result word
  always_comb begin
    show = hit_q && ((op_q == FN_FIND_KEY) || (op_q == FN_FIND_NAME));
    if (op_q == FN_APPEND) begin
      res.status = full_q ? ST_FULL : ST_OK;
    end else begin
      res.status = hit_q ? ST_OK : ST_NOT_FOUND;
    end
    res.position    = show ? (POS_W'(hit_idx_q) + POS_W'(1)) : '0;
    res.entry_count = POS_W'(fill_q);
    res.found_key   = show ? hit_key_q : '0;
    res.found_tag   = show ? hit_tag_q : '0;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    if (cmd_i.respond) out_vld_d = 1'b1;
  end

  // Memory port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      ptr_q     <= '0;
      ridx_q    <= '0;
      rvld_q    <= 1'b0;
      hit_q     <= 1'b0;
      full_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      ridx_q    <= ridx_d;
      rvld_q    <= rvld_d;
      hit_q     <= hit_d;
      full_q    <= full_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= item_i.func;
      key_q  <= item_i.rec_key;
      tag_q  <= item_i.rec_tag;
      name_q <= {item_i.name_bytes_hi, item_i.name_bytes_mid, item_i.name_bytes_lo};
    end
    if (cmd_i.scan && match_now) begin
      hit_idx_q <= ridx_q;
      hit_key_q <= rdata_q.key;
      hit_tag_q <= rdata_q.tag;
    end
    if (cmd_i.respond) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* sv/keyed_record_table_unit.sv */
// Top level of the keyed record table: append, delete and find over a compacted table.
//
//  channel   | direction | tdata fields, lowest bit first
//  s_axis    | in        | func, rec_key, rec_tag, name_bytes_lo, name_bytes_mid, name_bytes_hi
//  m_axis    | out       | status, position, entry_count, found_key, found_tag
//
// A find or a delete walks the table: the single read port of the record memory visits
// one entry a cycle, first to search, then to move later records forward.
// Reset empties the table through the fill counter alone; no clearing pass runs.
// A result waits in the output register while the next transaction is taken; an
// operation only stalls at its end if that register is still full.
module keyed_record_table_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // func, rec_key, rec_tag, name_bytes_lo, name_bytes_mid, name_bytes_hi, zero pad
  input  logic [krt_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status, position, entry_count, found_key, found_tag
  output logic [krt_pkg::OUT_W-1:0] m_axis_tdata
);
  import krt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item      = in_item_t'(s_axis_tdata);
  assign m_axis_tdata = OUT_W'(out_item);

  krt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  krt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (in_item),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_item_o  (out_item)
  );

endmodule

/* sv/krt_checker.sv */
// Port-level checks for the keyed record table, bound to the top level.
module krt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [krt_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [krt_pkg::OUT_W-1:0] m_axis_tdata
);
  import krt_pkg::*;

  out_item_t mo;
  assign mo = out_item_t'(m_axis_tdata);

  // Accept only known requests, then drop ready while the operation runs
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata) ##1 !s_axis_tready)
    else $error("request unknown or ready held after acceptance");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Failed operations report no record
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mo.status != ST_OK) |->
      (mo.position == '0) && (mo.found_key == '0) && (mo.found_tag == '0))
    else $error("failed operation carries record fields");

  // A found position lies inside the table
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mo.position != '0) |-> (mo.position <= mo.entry_count))
    else $error("position beyond entry count");

  // Full is only reported at capacity
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mo.status == ST_FULL) |-> (mo.entry_count == POS_W'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);

/* dv/keyed_record_table_unit_tb.sv */
// Self-checking testbench for the keyed record table: stream stimulus, table predictor, scoreboard.
module keyed_record_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int unsigned ITEM_TARGET = 650;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Table predictor with the queue of answers still owed by the block
  class krt_scoreboard;
    logic [KEY_W-1:0]  key_tab[CAPACITY];
    logic [TAG_W-1:0]  tag_tab[CAPACITY];
    logic [NAME_W-1:0] name_tab[CAPACITY];
    int unsigned       fill;
    out_item_t         answer_q[$];
    int unsigned       fail_count;
    int unsigned       checked_count;
    int unsigned       op_count[4];
    int unsigned       full_seen;
    int unsigned       miss_seen;
    int unsigned       peak_fill;

    function new();
      fill = 0;
      fail_count = 0;
      checked_count = 0;
      full_seen = 0;
      miss_seen = 0;
      peak_fill = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int unsigned pending();
      return answer_q.size();
    endfunction

    // First position holding this key, 1-based; 0 when absent
    function int unsigned key_pos(logic [KEY_W-1:0] key);
      for (int unsigned i = 0; i < fill; i++)
        if (key_tab[i] == key) return i + 1;
      return 0;
    endfunction

    // String equality: bytes agree up to and including the first zero
    function bit same_name(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
        if (a[8*i +: 8] == 8'h00) return 1'b1;
      end
      return 1'b1;
    endfunction

    // Apply one accepted request to the table and queue the answer it owes
    function void note_request(in_item_t req);
      out_item_t        ans;
      int unsigned      hit;
      logic [NAME_W-1:0] nm;
      ans = '0;
      ans.status = ST_OK;
      hit = 0;
      nm = {req.name_bytes_hi, req.name_bytes_mid, req.name_bytes_lo};
      op_count[req.func]++;
      case (req.func)
        FN_APPEND: begin
          if (fill >= CAPACITY) begin
            ans.status = ST_FULL;
          end else begin
            key_tab[fill]  = req.rec_key;
            tag_tab[fill]  = req.rec_tag;
            name_tab[fill] = nm;
            fill++;
          end
        end
        FN_DELETE: begin
          hit = key_pos(req.rec_key);
          if (hit == 0) begin
            ans.status = ST_NOT_FOUND;
          end else begin
            // close the gap left by the removed record
            for (int unsigned i = hit - 1; i + 1 < fill; i++) begin
              key_tab[i]  = key_tab[i+1];
              tag_tab[i]  = tag_tab[i+1];
              name_tab[i] = name_tab[i+1];
            end
            fill--;
          end
        end
        default: begin
          if (req.func == FN_FIND_KEY) begin
            hit = key_pos(req.rec_key);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              if (hit == 0 && same_name(name_tab[i], nm)) hit = i + 1;
          end
          if (hit == 0) begin
            ans.status = ST_NOT_FOUND;
          end else begin
            ans.position  = POS_W'(hit);
            ans.found_key = key_tab[hit-1];
            ans.found_tag = tag_tab[hit-1];
          end
        end
      endcase
      if (ans.status == ST_FULL) full_seen++;
      if (ans.status == ST_NOT_FOUND) miss_seen++;
      if (fill > peak_fill) peak_fill = fill;
      ans.entry_count = POS_W'(fill);
      answer_q.push_back(ans);
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      $display("%0t ns: mismatch on %s: expected 'h%0h, got 'h%0h", $time, what, want, got);
    endtask

    // Compare one delivered answer with the oldest one owed
    task check_response(out_item_t got);
      out_item_t want;
      if (answer_q.size() == 0) begin
        report("answer with none outstanding", 64'd0, 64'(got));
        return;
      end
      want = answer_q.pop_front();
      checked_count++;
      if (got.status !== want.status)
        report("status", 64'(want.status), 64'(got.status));
      if (got.position !== want.position)
        report("position", 64'(want.position), 64'(got.position));
      if (got.entry_count !== want.entry_count)
        report("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      if (got.found_key !== want.found_key)
        report("found_key", 64'(want.found_key), 64'(got.found_key));
      if (got.found_tag !== want.found_tag)
        report("found_tag", 64'(want.found_tag), 64'(got.found_tag));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  krt_scoreboard     sb;
  bit                hold_req = 1'b0;
  int unsigned       cycle_count = 0;
  int unsigned       sent = 0;
  logic [KEY_W-1:0]  key_pool[12];

  keyed_record_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: stall on a shifting pattern, or hold off for a long stretch on request
  initial begin : rx_pattern
    int unsigned seg_left;
    int unsigned mode;
    int unsigned phase;
    int unsigned n;
    seg_left = 0;
    mode = 0;
    phase = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      phase++;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (phase % 4 != 0);
        default: m_axis_tready <= (phase % 7 < 2);
      endcase
    end
  end

  // Check every delivered transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_response(out_item_t'(m_axis_tdata));
  end

  // Offer one request and hold it until taken
  task automatic send_item(input in_item_t req);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req);
    sent++;
  endtask

  task automatic idle_gap(input int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Pause the sender until every owed answer has arrived
  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t mk(func_e f, logic [31:0] key, logic [7:0] tag,
                                  logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
    in_item_t req;
    req = '0;
    req.func = f;
    req.rec_key = key;
    req.rec_tag = tag;
    req.name_bytes_lo = lo;
    req.name_bytes_mid = mid;
    req.name_bytes_hi = hi;
    return req;
  endfunction

  // Random name: random length, zero terminator unless full length, random bytes after it
  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] nm;
    int unsigned       len;
    int unsigned       i;
    nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
    len = $urandom_range(0, NAME_BYTES);
    for (i = 0; i < len; i++)
      if (nm[8*i +: 8] == 8'h00) nm[8*i +: 8] = 8'h20 + 8'($urandom_range(1, 90));
    if (len < NAME_BYTES) nm[8*len +: 8] = 8'h00;
    return nm;
  endfunction

  // Keep a stored name, scramble the bytes past its end, or spoil one byte of it
  function automatic logic [NAME_W-1:0] twist_name(logic [NAME_W-1:0] nm);
    int unsigned z;
    int unsigned i;
    z = NAME_BYTES;
    for (i = NAME_BYTES; i > 0; i--)
      if (nm[8*(i-1) +: 8] == 8'h00) z = i - 1;
    case ($urandom_range(0, 3))
      0: ;
      1, 2: for (i = z + 1; i < NAME_BYTES; i++) nm[8*i +: 8] = 8'($urandom);
      default: begin
        i = $urandom_range(0, (z < NAME_BYTES) ? z : NAME_BYTES - 1);
        nm[8*i +: 8] = nm[8*i +: 8] ^ 8'($urandom_range(1, 255));
      end
    endcase
    return nm;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic func_e pick_op(int unsigned wa, int unsigned wd, int unsigned wk);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < wa) return FN_APPEND;
    if (r < wa + wd) return FN_DELETE;
    if (r < wa + wd + wk) return FN_FIND_KEY;
    return FN_FIND_NAME;
  endfunction

  // Random request, aimed at stored records most of the time
  function automatic in_item_t make_item(func_e f);
    logic [NAME_W-1:0] nm;
    logic [KEY_W-1:0]  key;
    bit                aim;
    nm  = random_name();
    key = pick_key();
    aim = (sb.fill > 0) && ($urandom_range(0, 9) < 7);
    if (aim && (f == FN_DELETE || f == FN_FIND_KEY))
      key = sb.key_tab[$urandom_range(0, sb.fill - 1)];
    if (aim && f == FN_FIND_NAME)
      nm = twist_name(sb.name_tab[$urandom_range(0, sb.fill - 1)]);
    return mk(f, key, 8'($urandom), nm[63:0], nm[127:64], nm[159:128]);
  endfunction

  // Send n requests in bursts of random length with random gaps
  task automatic run_round(input int unsigned n, input int unsigned wa,
                           input int unsigned wd, input int unsigned wk);
    int unsigned burst;
    int unsigned k;
    burst = 0;
    for (k = 0; k < n; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
        burst = $urandom_range(1, 24);
      end
      send_item(make_item(pick_op(wa, wd, wk)));
      burst--;
    end
  endtask

  initial begin : stimulus
    int unsigned prof;
    sb = new();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    foreach (key_pool[i]) if (i > 3) key_pool[i] = $urandom;

    // Hold reset, then release it
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extreme keys and names, duplicates, removal and reordering
    send_item(mk(FN_FIND_KEY, 32'h0000_0000, 8'h00, '0, '0, '0));
    send_item(mk(FN_DELETE, 32'h8000_0000, 8'h00, '0, '0, '0));
    send_item(mk(FN_FIND_NAME, 32'hFFFF_FFFF, 8'hFF, '0, '0, '0));
    send_item(mk(FN_APPEND, 32'h8000_0000, 8'h00, '0, '0, '0));
    send_item(mk(FN_APPEND, 32'h7FFF_FFFF, 8'hFF, '1, '1, '1));
    send_item(mk(FN_APPEND, 32'hFFFF_FFFF, 8'h5A, 64'hCAFE_F00D_0063_6261, '1, '1));
    send_item(mk(FN_APPEND, 32'h7FFF_FFFF, 8'h11, 64'h0000_0000_0000_7A79, '0, '0));
    send_item(mk(FN_FIND_KEY, 32'h7FFF_FFFF, 8'hA5, '1, '0, '1));
    send_item(mk(FN_FIND_NAME, 32'h0000_0000, 8'h00, '1, '1, '1));
    send_item(mk(FN_FIND_NAME, 32'h1234_5678, 8'h00, 64'h1234_5678_0063_6261,
                 64'h0123_4567_89AB_CDEF, 32'h5555_AAAA));
    send_item(mk(FN_FIND_NAME, 32'h0000_0000, 8'h00, 64'hFFFF_FFFF_FFFF_FF00, '1, '1));
    send_item(mk(FN_FIND_NAME, 32'h0000_0000, 8'h00, '1, '1, 32'h7FFF_FFFF));
    send_item(mk(FN_FIND_NAME, 32'h0000_0000, 8'h00, 64'h0000_0000_0000_0061, '0, '0));
    send_item(mk(FN_DELETE, 32'h7FFF_FFFF, 8'hFF, '1, '1, '1));
    send_item(mk(FN_FIND_KEY, 32'h7FFF_FFFF, 8'h00, '0, '0, '0));
    send_item(mk(FN_FIND_NAME, 32'hFFFF_FFFF, 8'h00, '1, '1, '1));
    send_item(mk(FN_DELETE, 32'h8000_0000, 8'h00, '0, '0, '0));
    send_item(mk(FN_FIND_KEY, 32'hFFFF_FFFF, 8'h00, '0, '0, '0));
    send_item(mk(FN_DELETE, 32'h1234_5678, 8'h00, '0, '0, '0));
    wait_quiet();

    // Fill the table to capacity, then knock on it while full
    while (sb.fill < CAPACITY) run_round(16, 75, 0, 13);
    run_round(6, 100, 0, 0);

    // Long receiver hold-off while the sender keeps offering back to back
    hold_req = 1'b1;
    repeat (30) send_item(make_item(pick_op(20, 30, 25)));
    wait_quiet();

    // Random rounds that grow, shrink or search the table
    while (sent < ITEM_TARGET) begin
      prof = $urandom_range(0, 2);
      case (prof)
        0: run_round($urandom_range(40, 100), 50, 15, 20);
        1: run_round($urandom_range(40, 100), 15, 50, 20);
        default: run_round($urandom_range(40, 100), 20, 20, 30);
      endcase
      if ($urandom_range(0, 2) == 0) wait_quiet();
    end

    // Drain and let the block settle
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions: %0d appends, %0d deletes, %0d key finds, %0d name finds",
             sb.checked_count, sb.op_count[FN_APPEND], sb.op_count[FN_DELETE],
             sb.op_count[FN_FIND_KEY], sb.op_count[FN_FIND_NAME]);
    $display("Table-full answers %0d, no-match answers %0d, peak fill %0d, %0d cycles",
             sb.full_seen, sb.miss_seen, sb.peak_fill, cycle_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
